// ===== src/ebml_hdr_pkg.sv =====
// Shared types, status codes and helper functions for the EBML element header parser.
package ebml_hdr_pkg;

    localparam int IdWidth     = 29;
    localparam int SizeWidth   = 64;
    localparam int AccWidth    = 56;
    localparam int MaxHdrWidth = 8;
    localparam int HlenWidth   = 4;
    localparam int StatusWidth = 3;
    localparam int CfgWidth    = 29;

    localparam logic [MaxHdrWidth-1:0] MAX_HDR_RESET = 8'd12;
    localparam logic [IdWidth-1:0]     SEGMENT_ID_RESET = 29'h1853_8067;

    // Configuration register indexes
    localparam logic CFG_MAX_HEADER_BYTES = 1'b0;
    localparam logic CFG_SEGMENT_ID       = 1'b1;

    // Result status codes
    localparam logic [StatusWidth-1:0] ST_OK           = 3'd0;
    localparam logic [StatusWidth-1:0] ST_BAD_ID_LEAD  = 3'd1;
    localparam logic [StatusWidth-1:0] ST_TOO_LONG     = 3'd2;
    localparam logic [StatusWidth-1:0] ST_ZERO_SIZE    = 3'd3;
    localparam logic [StatusWidth-1:0] ST_UNKNOWN_SIZE = 3'd4;
    localparam logic [StatusWidth-1:0] ST_SHORT_WINDOW = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic       short_window;
    } in_item_t;

    typedef struct packed {
        logic [IdWidth-1:0]     element_id;
        logic [SizeWidth-1:0]   element_size;
        logic [HlenWidth-1:0]   header_length;
        logic [StatusWidth-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [MaxHdrWidth-1:0] max_header_bytes;
        logic [IdWidth-1:0]     segment_id;
    } cfg_t;

    // Number of size bytes following the size lead byte (lead must be nonzero).
    function automatic logic [2:0] size_extra_bytes(input logic [7:0] lead);
        logic [2:0] len;
        len = 3'd7;
        priority if (lead[7]) len = 3'd0;
        else if (lead[6])     len = 3'd1;
        else if (lead[5])     len = 3'd2;
        else if (lead[4])     len = 3'd3;
        else if (lead[3])     len = 3'd4;
        else if (lead[2])     len = 3'd5;
        else if (lead[1])     len = 3'd6;
        else                  len = 3'd7;
        return len;
    endfunction

    // All-ones value over the 7*(len+1) value bits of a size field.
    function automatic logic [AccWidth-1:0] unknown_size_mask(input logic [2:0] len);
        logic [AccWidth-1:0] m;
        unique case (len)
            3'd0: m = 56'h00_0000_0000_007F;
            3'd1: m = 56'h00_0000_0000_3FFF;
            3'd2: m = 56'h00_0000_001F_FFFF;
            3'd3: m = 56'h00_0000_0FFF_FFFF;
            3'd4: m = 56'h00_0007_FFFF_FFFF;
            3'd5: m = 56'h00_03FF_FFFF_FFFF;
            3'd6: m = 56'h01_FFFF_FFFF_FFFF;
            default: m = 56'hFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== src/ebml_hdr_in_stage.sv =====
// Input register stage: holds one accepted byte transaction until the decoder takes it.
module ebml_hdr_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ebml_hdr_pkg::in_item_t in_data,
    input  logic                   take,
    output logic                   held,
    output ebml_hdr_pkg::in_item_t item
);
    import ebml_hdr_pkg::*;

    logic     held_reg;
    logic     held_next;
    in_item_t item_reg;

    assign in_ready = !held_reg || take;
    assign held     = held_reg;
    assign item     = item_reg;

    always_comb
    begin
        held_next = held_reg;
        if (in_valid && in_ready)
        begin
            held_next = 1'b1;
        end
        else if (take)
        begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

endmodule

// ===== src/ebml_hdr_decode.sv =====
// Header decoder: parse state and combinational decode of one stream byte.
module ebml_hdr_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ebml_hdr_pkg::cfg_t      cfg,
    input  logic                    take,
    input  ebml_hdr_pkg::in_item_t  item,
    output logic                    res_valid,
    output ebml_hdr_pkg::out_item_t res
);
    import ebml_hdr_pkg::*;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_ID        = 2'd1;
    localparam logic [1:0] PH_SIZE_LEAD = 2'd2;
    localparam logic [1:0] PH_SIZE      = 2'd3;

    logic [1:0]          phase_reg,     phase_next;
    logic [IdWidth-1:0]  id_reg,        id_next;
    logic [1:0]          id_left_reg,   id_left_next;
    logic [AccWidth-1:0] size_reg,      size_next;
    logic [2:0]          size_left_reg, size_left_next;
    logic [2:0]          field_len_reg, field_len_next;
    logic [HlenWidth-1:0] consumed_reg, consumed_next;

    always_comb
    begin
        logic [7:0]           b;
        logic [2:0]           idlen;
        logic                 id_lead_ok;
        logic [2:0]           len;
        logic [8:0]           room;
        logic                 fin;
        logic [AccWidth-1:0]  fin_acc;
        logic [2:0]           fin_len;
        logic [HlenWidth-1:0] fin_cons;

        b          = item.data_byte;
        idlen      = 3'd0;
        id_lead_ok = 1'b1;
        len        = 3'd0;
        room       = 9'd0;
        fin        = 1'b0;
        fin_acc    = size_reg;
        fin_len    = field_len_reg;
        fin_cons   = consumed_reg;

        phase_next     = phase_reg;
        id_next        = id_reg;
        id_left_next   = id_left_reg;
        size_next      = size_reg;
        size_left_next = size_left_reg;
        field_len_next = field_len_reg;
        consumed_next  = consumed_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (take)
        begin
            if (item.start_req)
            begin
                // Drop any partial header and restart on this byte
                id_next        = '0;
                id_left_next   = '0;
                size_next      = '0;
                size_left_next = '0;
                field_len_next = '0;
                consumed_next  = '0;
                priority if (b[7])          idlen = 3'd1;
                else if (b[7:6] == 2'b01)   idlen = 3'd2;
                else if (b[7:5] == 3'b001)  idlen = 3'd3;
                else if (b[7:4] == 4'b0001) idlen = 3'd4;
                else                        id_lead_ok = 1'b0;

                priority if (item.short_window)
                begin
                    res_valid = 1'b1;
                    res.status = ST_SHORT_WINDOW;
                end
                else if (cfg.max_header_bytes == '0)
                begin
                    res_valid = 1'b1;
                    res.status = ST_TOO_LONG;
                end
                else if (!id_lead_ok)
                begin
                    res_valid = 1'b1;
                    res.status = ST_BAD_ID_LEAD;
                end
                else if (cfg.max_header_bytes < {5'd0, idlen})
                begin
                    res_valid = 1'b1;
                    res.status = ST_TOO_LONG;
                end
                else
                begin
                    id_next       = {21'd0, b};
                    consumed_next = 4'd1;
                    id_left_next  = 2'(idlen - 3'd1);
                    phase_next    = (idlen != 3'd1) ? PH_ID : PH_SIZE_LEAD;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_ID:
                    begin
                        id_next       = {id_reg[IdWidth-9:0], b};
                        consumed_next = consumed_reg + 4'd1;
                        id_left_next  = id_left_reg - 2'd1;
                        if (id_left_reg == 2'd1)
                        begin
                            phase_next = PH_SIZE_LEAD;
                        end
                    end
                    PH_SIZE_LEAD:
                    begin
                        len  = size_extra_bytes(b);
                        room = {1'b0, cfg.max_header_bytes} - {5'd0, consumed_reg};
                        priority if (cfg.max_header_bytes <= {4'd0, consumed_reg})
                        begin
                            res_valid = 1'b1;
                            res.status = ST_TOO_LONG;
                        end
                        else if (b == 8'd0)
                        begin
                            res_valid = 1'b1;
                            res.status = ST_ZERO_SIZE;
                        end
                        else if (room < ({6'd0, len} + 9'd1))
                        begin
                            res_valid = 1'b1;
                            res.status = ST_TOO_LONG;
                        end
                        else
                        begin
                            size_next      = {48'd0, b & (8'hFF >> ({1'b0, len} + 4'd1))};
                            consumed_next  = consumed_reg + 4'd1;
                            size_left_next = len;
                            field_len_next = len;
                            if (len == 3'd0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_SIZE;
                            end
                        end
                    end
                    PH_SIZE:
                    begin
                        size_next      = {size_reg[AccWidth-9:0], b};
                        consumed_next  = consumed_reg + 4'd1;
                        size_left_next = size_left_reg - 3'd1;
                        if (size_left_reg == 3'd1)
                        begin
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end

            if (fin)
            begin
                fin_acc  = size_next;
                fin_len  = field_len_next;
                fin_cons = consumed_next;
                res_valid = 1'b1;
                if (fin_acc == unknown_size_mask(fin_len))
                begin
                    if (id_reg == cfg.segment_id)
                    begin
                        res.element_id    = id_reg;
                        res.element_size  = '1;
                        res.header_length = fin_cons;
                        res.status        = ST_OK;
                    end
                    else
                    begin
                        res.status = ST_UNKNOWN_SIZE;
                    end
                end
                else
                begin
                    res.element_id    = id_reg;
                    res.element_size  = {8'd0, fin_acc};
                    res.header_length = fin_cons;
                    res.status        = ST_OK;
                end
            end

            // Every result ends the header
            if (res_valid)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            id_reg        <= '0;
            id_left_reg   <= '0;
            size_reg      <= '0;
            size_left_reg <= '0;
            field_len_reg <= '0;
            consumed_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            id_reg        <= id_next;
            id_left_reg   <= id_left_next;
            size_reg      <= size_next;
            size_left_reg <= size_left_next;
            field_len_reg <= field_len_next;
            consumed_reg  <= consumed_next;
        end
    end

endmodule

// ===== src/ebml_hdr_out_stage.sv =====
// Result register stage: holds one result transaction until the receiver takes it.
module ebml_hdr_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  ebml_hdr_pkg::out_item_t res,
    output logic                    can_load,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ebml_hdr_pkg::out_item_t out_data
);
    import ebml_hdr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

// ===== src/ebml_element_header_parser.sv =====
// Top level of the EBML element header parser.
//
// Input channel (in_valid/in_ready/in_data): one stream byte per transaction,
// with start_req on the first byte of a header and short_window sampled on that
// byte. Output channel (out_valid/out_ready/out_data): one result transaction
// per finished header or per error (element ID with marker bits, size, header
// length, status); zero results for bytes that only advance the decode.
// Configuration: cfg_we/cfg_index/cfg_data write max_header_bytes (index 0) or
// segment_id (index 1); write only while no transaction is in flight.
// Throughput: one byte per cycle while the receiver does not stall. A byte passes
// the input register, the combinational decoder and the result register, which
// raises out_valid when it loads the byte's result.
// Reset: asynchronous, active low; clears the parse state to idle, empties both
// register stages and loads the default limit (12) and segment ID.
// Receiver stall: the result register holds its transaction and the held byte
// waits in the input register, so in_ready drops; in_ready follows out_ready in
// the same cycle, so the input side resumes with no bubble once the stall ends.
module ebml_element_header_parser (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ebml_hdr_pkg::in_item_t                in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ebml_hdr_pkg::out_item_t               out_data,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [ebml_hdr_pkg::CfgWidth-1:0]     cfg_data
);
    import ebml_hdr_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      held;
    in_item_t  item;
    logic      can_load;
    logic      res_valid;
    out_item_t res;
    logic      take;

    // Consume the held byte only when the result register can store a result
    assign take = held && can_load;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_HEADER_BYTES: cfg_next.max_header_bytes = cfg_data[MaxHdrWidth-1:0];
                CFG_SEGMENT_ID:       cfg_next.segment_id       = cfg_data[IdWidth-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_header_bytes <= MAX_HDR_RESET;
            cfg_reg.segment_id       <= SEGMENT_ID_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ebml_hdr_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .take     (take),
        .held     (held),
        .item     (item)
    );

    ebml_hdr_decode u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ebml_hdr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== src/ebml_hdr_checker.sv =====
// Port-level checker for the EBML element header parser, bound to the top level.
module ebml_hdr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input ebml_hdr_pkg::out_item_t           out_data
);
    import ebml_hdr_pkg::*;

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Error results carry no ID, size or length
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.element_id == '0 && out_data.element_size == '0 &&
            out_data.header_length == '0)
        else $error("error result with nonzero fields");

    // A good header spans at least two and at most twelve bytes
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OK |->
            out_data.header_length >= 4'd2 && out_data.header_length <= 4'd12)
        else $error("header length out of range");

    // No result transaction first shows without an input byte accepted before it
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without an input byte");

endmodule

bind ebml_element_header_parser ebml_hdr_checker u_ebml_hdr_checker (.*);

// ===== test/ebml_element_header_parser_test.sv =====
// Self-checking testbench for the EBML element header parser: directed and random byte streams.
module ebml_element_header_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ebml_hdr_pkg::*;

    // Decode phase of the shadow parser
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ID,
        PH_SIZE_LEAD,
        PH_SIZE
    } parse_phase_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    in_item_t            in_data      = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    out_item_t           out_data;
    logic                cfg_we       = 1'b0;
    logic                cfg_index    = CFG_MAX_HEADER_BYTES;
    logic [CfgWidth-1:0] cfg_data     = '0;

    // Shadow copy of the configuration registers
    logic [7:0]          limit_cfg;
    logic [28:0]         segment_cfg;

    // Shadow copy of the parse state
    parse_phase_t        phase_q;
    logic [28:0]         id_acc;
    logic [1:0]          id_left;
    logic [55:0]         size_acc;
    logic [2:0]          size_left;
    logic [2:0]          size_len;
    logic [3:0]          consumed;

    // Headers decoded but not yet seen on the output, oldest first
    out_item_t           pending_headers[$];
    out_item_t           oldest_header;

    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    int                  decoded_bytes  = 0;
    int                  mismatch_count = 0;

    ebml_element_header_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Receiver: stall at random with the current percentage
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every result transaction against the oldest decoded header
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_headers.size() == 0)
            begin
                mismatch_count++;
                $error("unexpected result: id %h size %h length %0d status %0d",
                       out_data.element_id, out_data.element_size,
                       out_data.header_length, out_data.status);
            end
            else
            begin
                oldest_header = pending_headers.pop_front();
                if (out_data.element_id !== oldest_header.element_id)
                begin
                    mismatch_count++;
                    $error("element_id: expected %h, got %h",
                           oldest_header.element_id, out_data.element_id);
                end
                if (out_data.element_size !== oldest_header.element_size)
                begin
                    mismatch_count++;
                    $error("element_size: expected %h, got %h",
                           oldest_header.element_size, out_data.element_size);
                end
                if (out_data.header_length !== oldest_header.header_length)
                begin
                    mismatch_count++;
                    $error("header_length: expected %0d, got %0d",
                           oldest_header.header_length, out_data.header_length);
                end
                if (out_data.status !== oldest_header.status)
                begin
                    mismatch_count++;
                    $error("status: expected %0d, got %0d",
                           oldest_header.status, out_data.status);
                end
            end
        end
    end

    // Queue a decoded header and drop back to idle, as every result does
    task automatic push_header(input logic [28:0] id, input logic [63:0] size,
                               input logic [3:0] hlen, input logic [2:0] st);
        out_item_t r;
        r.element_id    = id;
        r.element_size  = size;
        r.header_length = hlen;
        r.status        = st;
        pending_headers.push_back(r);
        phase_q = PH_IDLE;
    endtask

    // Errors carry no ID, size or length
    task automatic push_failure(input logic [2:0] st);
        push_header('0, '0, '0, st);
    endtask

    // Close the size field: an all-ones size is only legal on the segment ID
    task automatic close_size();
        logic [55:0] all_ones;
        all_ones = (56'h1 << (7 * (int'(size_len) + 1))) - 56'h1;
        if (size_acc == all_ones)
        begin
            if (id_acc == segment_cfg)
                push_header(id_acc, '1, consumed, ST_OK);
            else
                push_failure(ST_UNKNOWN_SIZE);
        end
        else
            push_header(id_acc, 64'(size_acc), consumed, ST_OK);
    endtask

    // Advance the shadow parser by one accepted byte
    task automatic decode_byte(input in_item_t it);
        int         id_len;
        int         msb;
        int         len;
        logic [7:0] b;
        b = it.data_byte;
        if (it.start_req)
        begin
            // A start always wipes any partial header first
            id_acc    = '0;
            id_left   = '0;
            size_acc  = '0;
            size_left = '0;
            size_len  = '0;
            consumed  = '0;
            if (b[7])
                id_len = 1;
            else if (b[6])
                id_len = 2;
            else if (b[5])
                id_len = 3;
            else if (b[4])
                id_len = 4;
            else
                id_len = 0;
            // Short window wins over everything, then a zero limit, then the lead
            if (it.short_window)
                push_failure(ST_SHORT_WINDOW);
            else if (limit_cfg == 8'd0)
                push_failure(ST_TOO_LONG);
            else if (id_len == 0)
                push_failure(ST_BAD_ID_LEAD);
            else if (int'(limit_cfg) < id_len)
                push_failure(ST_TOO_LONG);
            else
            begin
                id_acc   = 29'(b);
                consumed = 4'd1;
                id_left  = 2'(id_len - 1);
                phase_q  = (id_left != 2'd0) ? PH_ID : PH_SIZE_LEAD;
            end
        end
        else
        begin
            case (phase_q)
                PH_ID:
                begin
                    id_acc   = {id_acc[20:0], b};
                    consumed = consumed + 4'd1;
                    id_left  = id_left - 2'd1;
                    if (id_left == 2'd0)
                        phase_q = PH_SIZE_LEAD;
                end
                PH_SIZE_LEAD:
                begin
                    if (int'(limit_cfg) <= int'(consumed))
                        push_failure(ST_TOO_LONG);
                    else if (b == 8'd0)
                        push_failure(ST_ZERO_SIZE);
                    else
                    begin
                        msb = 7;
                        while (!b[msb])
                            msb--;
                        len = 7 - msb;
                        // The whole size field must fit in the remaining room
                        if (int'(limit_cfg) - int'(consumed) < 1 + len)
                            push_failure(ST_TOO_LONG);
                        else
                        begin
                            size_acc  = 56'(b & ((8'h1 << msb) - 8'h1));
                            consumed  = consumed + 4'd1;
                            size_left = 3'(len);
                            size_len  = 3'(len);
                            if (len == 0)
                                close_size();
                            else
                                phase_q = PH_SIZE;
                        end
                    end
                end
                PH_SIZE:
                begin
                    size_acc  = {size_acc[47:0], b};
                    consumed  = consumed + 4'd1;
                    size_left = size_left - 3'd1;
                    if (size_left == 3'd0)
                        close_size();
                end
                default:
                    phase_q = PH_IDLE;
            endcase
        end
    endtask

    // Offer one byte after a random gap; hold it until accepted, then decode it
    task automatic send_byte(input in_item_t it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        if (it.start_req || phase_q != PH_IDLE)
            decoded_bytes++;
        decode_byte(it);
    endtask

    // Send n bytes, most significant first; the first one carries the start flag
    task automatic send_seq(input logic [95:0] bytes, input int n, input logic sw);
        in_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.data_byte    = bytes[8*(n-1-i) +: 8];
            it.start_req    = (i == 0);
            it.short_window = (i == 0) ? sw : 1'($urandom);
            send_byte(it);
        end
    endtask

    // Drop valid and hold off until every decoded header has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_headers.size() != 0)
            @(posedge clk);
        // Bytes that give no result may still sit in the pipeline
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [CfgWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_MAX_HEADER_BYTES)
            limit_cfg = value[7:0];
        else
            segment_cfg = value[28:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int id_byte_count(input logic [28:0] v);
        if (v >= 29'h100_0000)
            return 4;
        else if (v >= 29'h1_0000)
            return 3;
        else if (v >= 29'h100)
            return 2;
        return 1;
    endfunction

    // Build an ID with a legal length marker on its lead byte
    function automatic logic [28:0] random_valid_id();
        int          n;
        logic [7:0]  lead;
        logic [31:0] v;
        n    = $urandom_range(1, 4);
        lead = (8'h80 >> (n - 1)) | (8'($urandom) & (8'h7F >> (n - 1)));
        v    = 32'(lead);
        for (int i = 1; i < n; i++)
            v = {v[23:0], 8'($urandom)};
        return v[28:0];
    endfunction

    // One random header: mostly well formed, some truncated, some garbage or stray bytes
    task automatic send_random_header();
        in_item_t    it;
        logic [95:0] hdr;
        logic [28:0] idv;
        logic [7:0]  lead;
        int          hlen;
        int          n;
        int          szl;
        int          kind;
        int          fill;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            // Stray bytes: ignored in idle, consumed in mid header
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                it.data_byte    = 8'($urandom);
                it.start_req    = 1'b0;
                it.short_window = 1'($urandom);
                send_byte(it);
            end
            return;
        end
        if (kind < 14)
        begin
            hdr  = 96'($urandom);
            hlen = $urandom_range(1, 4);
        end
        else
        begin
            // Reuse the segment ID now and then so unknown sizes get accepted
            idv  = ($urandom_range(3) == 0) ? segment_cfg : random_valid_id();
            hlen = id_byte_count(idv);
            hdr  = 96'(idv);
            szl  = $urandom_range(1, 8);
            fill = $urandom_range(9);
            if (fill == 1)
            begin
                hdr  = {hdr[87:0], 8'h00};
                hlen = hlen + 1;
            end
            else
            begin
                case (fill)
                    0:       lead = 8'hFF >> (szl - 1);
                    2:       lead = 8'h80 >> (szl - 1);
                    default: lead = (8'h80 >> (szl - 1)) | (8'($urandom) & (8'h7F >> (szl - 1)));
                endcase
                hdr  = {hdr[87:0], lead};
                hlen = hlen + 1;
                for (int i = 1; i < szl; i++)
                begin
                    hdr  = {hdr[87:0], (fill == 0) ? 8'hFF : (fill == 2) ? 8'h00 : 8'($urandom)};
                    hlen = hlen + 1;
                end
            end
            if ($urandom_range(9) == 0 && hlen > 1)
            begin
                // Cut the header short; the next start drops it
                n    = $urandom_range(1, hlen - 1);
                hdr  = hdr >> (8 * n);
                hlen = hlen - n;
            end
        end
        send_seq(hdr, hlen, $urandom_range(11) == 0);
    endtask

    // Legal headers: smallest, and largest ID with largest known size
    task automatic test_valid_headers();
        send_seq(96'h80_80, 2, 1'b0);
        send_seq(96'h1FFF_FFFF_01FF_FFFF_FFFF_FFFE, 12, 1'b0);
    endtask

    // Error statuses under the reset configuration, all but too long, and an unknown size on the segment ID
    task automatic test_error_codes();
        send_seq(96'h00, 1, 1'b0);
        send_seq(96'h81, 1, 1'b1);
        send_seq(96'h81_00, 2, 1'b0);
        send_seq(96'h81_FF, 2, 1'b0);
        send_seq(96'h1853_8067_FF, 5, 1'b0);
    endtask

    // Bytes outside a header are ignored; a start in mid header restarts decoding
    task automatic test_stream_framing();
        in_item_t it;
        it.data_byte    = 8'hAA;
        it.start_req    = 1'b0;
        it.short_window = 1'b1;
        send_byte(it);
        send_seq(96'h41, 1, 1'b0);
        send_seq(96'h82_81, 2, 1'b0);
    endtask

    // Limit checks on the ID and size fields, and segment ID extremes
    task automatic test_limits_and_segment();
        wait_idle();
        write_register(CFG_MAX_HEADER_BYTES, 29'd0);
        send_seq(96'h81, 1, 1'b0);
        wait_idle();
        write_register(CFG_MAX_HEADER_BYTES, 29'd1);
        send_seq(96'h81_81, 2, 1'b0);
        wait_idle();
        write_register(CFG_MAX_HEADER_BYTES, 29'd3);
        send_seq(96'h41_02_41, 3, 1'b0);
        wait_idle();
        write_register(CFG_MAX_HEADER_BYTES, 29'd255);
        write_register(CFG_SEGMENT_ID, 29'h1FFF_FFFF);
        send_seq(96'h1FFF_FFFF_FF, 5, 1'b0);
        wait_idle();
        write_register(CFG_SEGMENT_ID, 29'd0);
        send_seq(96'h81_FF, 2, 1'b0);
    endtask

    // Random streams across idling phases and configurations
    task automatic test_random_traffic();
        int target;
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_register(CFG_MAX_HEADER_BYTES, 29'(MAX_HDR_RESET));
                    write_register(CFG_SEGMENT_ID, SEGMENT_ID_RESET);
                end
                1:
                begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                    write_register(CFG_MAX_HEADER_BYTES, 29'd255);
                    write_register(CFG_SEGMENT_ID, random_valid_id());
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                    write_register(CFG_MAX_HEADER_BYTES, 29'($urandom_range(1, 12)));
                    write_register(CFG_SEGMENT_ID, random_valid_id());
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                    write_register(CFG_MAX_HEADER_BYTES, 29'($urandom_range(2, 14)));
                    write_register(CFG_SEGMENT_ID, SEGMENT_ID_RESET);
                end
            endcase
            target = decoded_bytes + 100;
            while (decoded_bytes < target)
                send_random_header();
        end
    endtask

    initial
    begin
        limit_cfg   = MAX_HDR_RESET;
        segment_cfg = SEGMENT_ID_RESET;
        phase_q     = PH_IDLE;
        id_acc      = '0;
        id_left     = '0;
        size_acc    = '0;
        size_left   = '0;
        size_len    = '0;
        consumed    = '0;
        // Hold reset, then release it on a rising edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_headers();
        test_error_codes();
        test_stream_framing();
        test_limits_and_segment();
        test_random_traffic();

        // Drain: wait for the last results, bounded, then check for any still missing
        in_valid <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < 5000 && pending_headers.size() != 0; i++)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (pending_headers.size() != 0)
        begin
            mismatch_count += pending_headers.size();
            $error("%0d expected results never arrived", pending_headers.size());
        end
        if (mismatch_count == 0)
            $display("ebml_element_header_parser_test: done, clean");
        else
            $display("ebml_element_header_parser_test: done, errors");
        $finish;
    end

    // Watchdog: end a hung run
    initial
    begin
        #2_000_000;
        $display("ebml_element_header_parser_test: done, errors");
        $finish;
    end

endmodule
